[hdl/bdr_pkg.sv]
`default_nettype none
package bdr_pkg;

  // Limits of the scaler
  localparam int unsigned MAX_OUT_EDGE = 640;
  localparam int unsigned MAX_SRC_EDGE = 4096;

  // Field and register widths
  localparam int unsigned PIX_W  = 8;
  localparam int unsigned SRC_W  = 13;
  localparam int unsigned DST_W  = 10;
  localparam int unsigned CH     = 3;
  localparam int unsigned SUM_W  = 32;
  localparam int unsigned CNT_W  = 25;
  localparam int unsigned PROD_W = 2 * SRC_W;
  localparam int unsigned ADDR_W = $clog2(MAX_OUT_EDGE);
  localparam int unsigned CIDX_W = 2;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_SRC_HEIGHT = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_DST_WIDTH  = 2'd2;
  localparam logic [CIDX_W-1:0] CFG_DST_HEIGHT = 2'd3;

  localparam logic [SRC_W-1:0] SRC_MAX_V = SRC_W'(MAX_SRC_EDGE);
  localparam logic [SRC_W-1:0] OUT_MAX_V = SRC_W'(MAX_OUT_EDGE);

  // Multiplier operand select
  typedef enum logic [1:0] {
    MUL_COUNT,
    MUL_COL,
    MUL_ROW
  } mul_sel_t;

  // Divider operand select
  typedef enum logic [2:0] {
    DIV_MEAN,
    DIV_COL,
    DIV_ROW,
    DIV_ICOL,
    DIV_IROW
  } div_sel_t;

  // Destination of a divider result
  typedef enum logic [2:0] {
    ST_OUT,
    ST_COL,
    ST_ROW,
    ST_ICOL,
    ST_IROW
  } store_sel_t;

  typedef struct packed {
    logic       load_pix;
    logic       ram_rd;
    logic       acc;
    logic       mul_en;
    mul_sel_t   mul_sel;
    logic       div_start;
    div_sel_t   div_sel;
    logic       store;
    store_sel_t store_sel;
    logic       advance;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_free;
    logic emit;
    logic need_col;
    logic need_row;
  } dp_stat_t;

endpackage
`default_nettype wire

[hdl/bdr_ram.sv]
`default_nettype none
module bdr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[addr];
    end
  end

endmodule
`default_nettype wire

[hdl/bdr_div.sv]
`default_nettype none
module bdr_div (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  start,
  input  wire logic [bdr_pkg::CH-1:0][bdr_pkg::SUM_W-1:0] dividend,
  input  wire logic [bdr_pkg::CNT_W-1:0]             divisor,
  output logic                                       busy,
  output logic      [bdr_pkg::CH-1:0][bdr_pkg::SUM_W-1:0] quot
);
  import bdr_pkg::*;

  localparam int unsigned STEP_W = $clog2(SUM_W + 1);

  logic [CH-1:0][SUM_W-1:0] quot_r;
  logic [CH-1:0][CNT_W-1:0] rem_r;
  logic [CNT_W-1:0]         dvs_r;
  logic [STEP_W-1:0]        step_r;

  // counter: one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else if (start) begin
      step_r <= STEP_W'(SUM_W);
    end else if (step_r != '0) begin
      step_r <= step_r - 1'b1;
    end
  end

  // restoring divide, all lanes share the divisor
  always_ff @(posedge clk) begin
    logic [CNT_W:0] trial;
    if (start) begin
      quot_r <= dividend;
      rem_r  <= '0;
      dvs_r  <= divisor;
    end else if (step_r != '0) begin
      for (int i = 0; i < CH; i++) begin
        trial = {rem_r[i], quot_r[i][SUM_W-1]};
        if (trial >= {1'b0, dvs_r}) begin
          rem_r[i]  <= CNT_W'(trial - {1'b0, dvs_r});
          quot_r[i] <= {quot_r[i][SUM_W-2:0], 1'b1};
        end else begin
          rem_r[i]  <= trial[CNT_W-1:0];
          quot_r[i] <= {quot_r[i][SUM_W-2:0], 1'b0};
        end
      end
    end
  end

  assign busy = (step_r != '0);
  assign quot = quot_r;

endmodule
`default_nettype wire

[hdl/bdr_dp.sv]
`default_nettype none
module bdr_dp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_wr_en,
  input  wire logic [bdr_pkg::CIDX_W-1:0]  cfg_index,
  input  wire logic [bdr_pkg::SRC_W-1:0]   cfg_wdata,
  input  wire logic [bdr_pkg::PIX_W-1:0]   in_red,
  input  wire logic [bdr_pkg::PIX_W-1:0]   in_green,
  input  wire logic [bdr_pkg::PIX_W-1:0]   in_blue,
  input  wire logic                        out_stall,
  output logic                             out_valid,
  output logic      [bdr_pkg::PIX_W-1:0]   out_red,
  output logic      [bdr_pkg::PIX_W-1:0]   out_green,
  output logic      [bdr_pkg::PIX_W-1:0]   out_blue,
  output logic      [bdr_pkg::DST_W-1:0]   out_col,
  output logic      [bdr_pkg::DST_W-1:0]   out_row,
  output logic                             out_frame_end,
  input  wire bdr_pkg::dp_cmd_t            cmd,
  output bdr_pkg::dp_stat_t                stat
);
  import bdr_pkg::*;

  // configuration registers
  logic [SRC_W-1:0] src_width_r, src_height_r;
  logic [DST_W-1:0] dst_width_r, dst_height_r;
  // effective sizes
  logic [SRC_W-1:0] sw, sh, dw, dh, lim_w, lim_h;

  // scan position
  logic [SRC_W-1:0] src_col_r, src_row_r, col_bnd_r, row_bnd_r;
  logic [SRC_W-1:0] col_start_r, band_top_r, col_first_r, row_first_r;
  logic [DST_W-1:0] cell_col_r, cell_row_r;

  logic [CH-1:0][PIX_W-1:0] pix_r;
  logic [CH-1:0][SUM_W-1:0] sum_r, sum_new, ram_rdata, div_dend, quot;
  logic [PROD_W-1:0]        prod_r;
  logic [SRC_W-1:0]         mul_a, mul_b;
  logic [CNT_W-1:0]         div_dvs;
  logic                     div_busy, first_row, col_last, row_last, wrap, frame_wrap;
  logic                     out_valid_r;

  // clamp register values to legal sizes
  always_comb begin
    sw = (src_width_r == '0) ? SRC_W'(1) :
         (src_width_r > SRC_MAX_V) ? SRC_MAX_V : src_width_r;
    sh = (src_height_r == '0) ? SRC_W'(1) :
         (src_height_r > SRC_MAX_V) ? SRC_MAX_V : src_height_r;
    lim_w = (sw < OUT_MAX_V) ? sw : OUT_MAX_V;
    lim_h = (sh < OUT_MAX_V) ? sh : OUT_MAX_V;
    dw = (dst_width_r == '0) ? SRC_W'(1) :
         ({3'b0, dst_width_r} > lim_w) ? lim_w : {3'b0, dst_width_r};
    dh = (dst_height_r == '0) ? SRC_W'(1) :
         ({3'b0, dst_height_r} > lim_h) ? lim_h : {3'b0, dst_height_r};
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= SRC_W'(640);
      src_height_r <= SRC_W'(640);
      dst_width_r  <= DST_W'(640);
      dst_height_r <= DST_W'(640);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_SRC_WIDTH:  src_width_r  <= cfg_wdata;
        CFG_SRC_HEIGHT: src_height_r <= cfg_wdata;
        CFG_DST_WIDTH:  dst_width_r  <= cfg_wdata[DST_W-1:0];
        CFG_DST_HEIGHT: dst_height_r <= cfg_wdata[DST_W-1:0];
        default: ;
      endcase
    end
  end

  // position flags of the current pixel
  assign first_row  = (src_row_r == band_top_r);
  assign col_last   = (src_col_r + 1'b1 == col_bnd_r);
  assign row_last   = (src_row_r + 1'b1 == row_bnd_r);
  assign wrap       = (src_col_r + 1'b1 >= sw);
  assign frame_wrap = (src_row_r + 1'b1 >= sh);

  // column sums, one word per output column
  bdr_ram #(
    .WIDTH(CH * SUM_W),
    .DEPTH(MAX_OUT_EDGE)
  ) u_sums (
    .clk   (clk),
    .wr_en (cmd.acc),
    .rd_en (cmd.ram_rd),
    .addr  (cell_col_r),
    .wdata (sum_new),
    .rdata (ram_rdata)
  );

  always_comb begin
    for (int i = 0; i < CH; i++) begin
      sum_new[i] = first_row ? {{(SUM_W-PIX_W){1'b0}}, pix_r[i]}
                             : ram_rdata[i] + {{(SUM_W-PIX_W){1'b0}}, pix_r[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_pix) begin
      pix_r <= {in_blue, in_green, in_red};
    end
    if (cmd.acc) begin
      sum_r <= sum_new;
    end
  end

  // shared multiplier: cell area or next cell edge numerator
  always_comb begin
    unique case (cmd.mul_sel)
      MUL_COUNT: begin
        mul_a = col_bnd_r - col_start_r;
        mul_b = row_bnd_r - band_top_r;
      end
      MUL_COL: begin
        mul_a = {3'b0, cell_col_r} + 1'b1;
        mul_b = sw;
      end
      MUL_ROW: begin
        mul_a = {3'b0, cell_row_r} + 1'b1;
        mul_b = sh;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= mul_a * mul_b;
    end
  end

  // divider operands
  always_comb begin
    div_dend = '0;
    div_dvs  = CNT_W'(1);
    unique case (cmd.div_sel)
      DIV_MEAN: begin
        for (int i = 0; i < CH; i++) begin
          div_dend[i] = sum_r[i] + {{(SUM_W-CNT_W+1){1'b0}}, prod_r[CNT_W-1:1]};
        end
        div_dvs = prod_r[CNT_W-1:0];
      end
      DIV_COL: begin
        div_dend[0] = {{(SUM_W-PROD_W){1'b0}}, prod_r};
        div_dvs     = {{(CNT_W-SRC_W){1'b0}}, dw};
      end
      DIV_ROW: begin
        div_dend[0] = {{(SUM_W-PROD_W){1'b0}}, prod_r};
        div_dvs     = {{(CNT_W-SRC_W){1'b0}}, dh};
      end
      DIV_ICOL: begin
        div_dend[0] = {{(SUM_W-SRC_W){1'b0}}, sw};
        div_dvs     = {{(CNT_W-SRC_W){1'b0}}, dw};
      end
      DIV_IROW: begin
        div_dend[0] = {{(SUM_W-SRC_W){1'b0}}, sh};
        div_dvs     = {{(CNT_W-SRC_W){1'b0}}, dh};
      end
      default: ;
    endcase
  end

  bdr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dend),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .quot     (quot)
  );

  // scan position, cell edges
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wr_en) begin
      src_col_r   <= '0;
      src_row_r   <= '0;
      cell_col_r  <= '0;
      cell_row_r  <= '0;
      col_start_r <= '0;
      band_top_r  <= '0;
      col_bnd_r   <= '0;
      row_bnd_r   <= '0;
    end else if (cmd.advance) begin
      if (wrap) begin
        src_col_r   <= '0;
        cell_col_r  <= '0;
        col_start_r <= '0;
        col_bnd_r   <= col_first_r;
        if (frame_wrap) begin
          src_row_r  <= '0;
          cell_row_r <= '0;
          band_top_r <= '0;
          row_bnd_r  <= row_first_r;
        end else begin
          src_row_r <= src_row_r + 1'b1;
          if (src_row_r + 1'b1 >= row_bnd_r) begin
            cell_row_r <= cell_row_r + 1'b1;
            band_top_r <= src_row_r + 1'b1;
          end
        end
      end else begin
        src_col_r <= src_col_r + 1'b1;
        if (src_col_r + 1'b1 >= col_bnd_r) begin
          cell_col_r  <= cell_col_r + 1'b1;
          col_start_r <= col_bnd_r;
        end
      end
    end else if (cmd.store) begin
      unique case (cmd.store_sel)
        ST_COL:  col_bnd_r <= quot[0][SRC_W-1:0];
        ST_ROW:  row_bnd_r <= quot[0][SRC_W-1:0];
        ST_ICOL: col_bnd_r <= quot[0][SRC_W-1:0];
        ST_IROW: row_bnd_r <= quot[0][SRC_W-1:0];
        default: ;
      endcase
    end
  end

  // first cell edges, reused at each line and frame start
  always_ff @(posedge clk) begin
    if (cmd.store && cmd.store_sel == ST_ICOL) begin
      col_first_r <= quot[0][SRC_W-1:0];
    end
    if (cmd.store && cmd.store_sel == ST_IROW) begin
      row_first_r <= quot[0][SRC_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.store && cmd.store_sel == ST_OUT) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store && cmd.store_sel == ST_OUT) begin
      out_red       <= quot[0][PIX_W-1:0];
      out_green     <= quot[1][PIX_W-1:0];
      out_blue      <= quot[2][PIX_W-1:0];
      out_col       <= cell_col_r;
      out_row       <= cell_row_r;
      out_frame_end <= ({3'b0, cell_col_r} + 1'b1 == dw) &&
                       ({3'b0, cell_row_r} + 1'b1 == dh);
    end
  end

  assign out_valid     = out_valid_r;
  assign stat.div_busy = div_busy;
  assign stat.out_free = !out_valid_r || !out_stall;
  assign stat.emit     = col_last && row_last;
  assign stat.need_col = !wrap && (src_col_r + 1'b1 >= col_bnd_r);
  assign stat.need_row = wrap && !frame_wrap && (src_row_r + 1'b1 >= row_bnd_r);

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.store && cmd.store_sel == ST_OUT) |-> (!out_valid_r || !out_stall))
    else $error("result register overwritten");

  // scan column stays inside the source line
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    src_col_r < sw)
    else $error("source column out of range");

  // output column stays inside the output line
  a_cell_range: assert property (@(posedge clk) disable iff (!rst_n)
    {3'b0, cell_col_r} < dw)
    else $error("cell column out of range");

endmodule
`default_nettype wire

[hdl/bdr_ctrl.sv]
`default_nettype none
module bdr_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire bdr_pkg::dp_stat_t  stat,
  output bdr_pkg::dp_cmd_t        cmd
);
  import bdr_pkg::*;

  typedef enum logic [3:0] {
    S_INIT_COL,
    S_INIT_COLW,
    S_INIT_ROW,
    S_INIT_ROWW,
    S_IDLE,
    S_READ,
    S_ACC,
    S_COUNT,
    S_MEAN,
    S_MEANW,
    S_EMIT,
    S_ADV,
    S_EDGE_MUL,
    S_EDGE_DIV,
    S_EDGE_W
  } state_t;

  state_t state_r, state_nxt;
  logic   edge_row_r, edge_row_nxt;

  // next state and command decode
  always_comb begin
    state_nxt    = state_r;
    edge_row_nxt = edge_row_r;
    cmd          = '0;
    unique case (state_r)
      S_INIT_COL: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_ICOL;
        state_nxt     = S_INIT_COLW;
      end
      S_INIT_COLW: begin
        if (!stat.div_busy) begin
          cmd.store     = 1'b1;
          cmd.store_sel = ST_ICOL;
          state_nxt     = S_INIT_ROW;
        end
      end
      S_INIT_ROW: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_IROW;
        state_nxt     = S_INIT_ROWW;
      end
      S_INIT_ROWW: begin
        if (!stat.div_busy) begin
          cmd.store     = 1'b1;
          cmd.store_sel = ST_IROW;
          state_nxt     = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_pix = 1'b1;
          cmd.ram_rd   = 1'b1;
          state_nxt    = S_READ;
        end
      end
      S_READ: state_nxt = S_ACC;
      S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = stat.emit ? S_COUNT : S_ADV;
      end
      S_COUNT: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_COUNT;
        state_nxt   = S_MEAN;
      end
      S_MEAN: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_MEAN;
        state_nxt     = S_MEANW;
      end
      S_MEANW: begin
        if (!stat.div_busy) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.store     = 1'b1;
          cmd.store_sel = ST_OUT;
          state_nxt     = S_ADV;
        end
      end
      S_ADV: begin
        cmd.advance = 1'b1;
        priority if (stat.need_col) begin
          edge_row_nxt = 1'b0;
          state_nxt    = S_EDGE_MUL;
        end else if (stat.need_row) begin
          edge_row_nxt = 1'b1;
          state_nxt    = S_EDGE_MUL;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EDGE_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = edge_row_r ? MUL_ROW : MUL_COL;
        state_nxt   = S_EDGE_DIV;
      end
      S_EDGE_DIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = edge_row_r ? DIV_ROW : DIV_COL;
        state_nxt     = S_EDGE_W;
      end
      S_EDGE_W: begin
        if (!stat.div_busy) begin
          cmd.store     = 1'b1;
          cmd.store_sel = edge_row_r ? ST_ROW : ST_COL;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_INIT_COL;
    endcase
  end

  // state register; a config write restarts the frame setup
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wr_en) begin
      state_r    <= S_INIT_COL;
      edge_row_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      edge_row_r <= edge_row_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  // pixel transfer only in idle, which then launches the sum read
  a_accept_read: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !cfg_wr_en) |=> (state_r == S_READ))
    else $error("accepted pixel not processed");

  // the divider is never restarted while running a step of this item
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_start && state_r != S_INIT_COL) |-> !stat.div_busy)
    else $error("divider restarted while busy");

  // sums are only written right after the read
  a_acc_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.acc |-> $past(state_r == S_READ))
    else $error("sum write without read");

endmodule
`default_nettype wire

[hdl/box_downscale_rgb.sv]
// A pixel passes through transfer, sum read, accumulate and advance; one that closes
// a cell adds area multiply, mean divide and store, and entering a new column or
// row cell adds edge multiply, divide and store. One pixel is taken at a time:
// in_stall stays high until the last is done, also through any out_stall wait.
// Reset (rst_n, synchronous) and every config write restart the frame; edge setup
// then holds in_stall high. No clearing pass.
`default_nettype none
module box_downscale_rgb (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_wr_en,
  input  wire logic [bdr_pkg::CIDX_W-1:0] cfg_index,
  input  wire logic [bdr_pkg::SRC_W-1:0]  cfg_wdata,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [bdr_pkg::PIX_W-1:0]  in_red,
  input  wire logic [bdr_pkg::PIX_W-1:0]  in_green,
  input  wire logic [bdr_pkg::PIX_W-1:0]  in_blue,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic      [bdr_pkg::PIX_W-1:0]  out_red,
  output logic      [bdr_pkg::PIX_W-1:0]  out_green,
  output logic      [bdr_pkg::PIX_W-1:0]  out_blue,
  output logic      [bdr_pkg::DST_W-1:0]  out_col,
  output logic      [bdr_pkg::DST_W-1:0]  out_row,
  output logic                            out_frame_end
);
  import bdr_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  bdr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // sums, edges, divider, output register
  bdr_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_red        (in_red),
    .in_green      (in_green),
    .in_blue       (in_blue),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_col       (out_col),
    .out_row       (out_row),
    .out_frame_end (out_frame_end),
    .cmd           (cmd),
    .stat          (stat)
  );

endmodule
`default_nettype wire

[tb/tb_top.sv]
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bdr_pkg::*;

  typedef struct {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [DST_W-1:0] col;
    logic [DST_W-1:0] row;
    logic             frame_end;
  } cell_mean_t;

  // Directed pixel with an optional typed-in mean
  typedef struct {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    bit               typed;
    cell_mean_t       mean;
  } pixel_row_t;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 150;
  localparam int HOLD_CYCLES    = 400;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_wr_en = 1'b0;
  logic [CIDX_W-1:0] cfg_index = CFG_SRC_WIDTH;
  logic [SRC_W-1:0] cfg_wdata = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [PIX_W-1:0] in_red = '0, in_green = '0, in_blue = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [PIX_W-1:0] out_red, out_green, out_blue;
  logic [DST_W-1:0] out_col, out_row;
  logic             out_frame_end;

  box_downscale_rgb dut (.*);

  always #5 clk = ~clk;

  // Scaler shadow state
  int unsigned reg_sw, reg_sh, reg_dw, reg_dh;
  int unsigned red_acc[MAX_OUT_EDGE], green_acc[MAX_OUT_EDGE], blue_acc[MAX_OUT_EDGE];
  int unsigned px_col, px_row, cell_x, cell_y, col_end, row_end, band_start;

  cell_mean_t mean_q[$];
  int  fail_count = 0;
  int  idle_cycles = 0;
  bit  quiet = 1'b0;
  bit  hold_req = 1'b0;

  function automatic int unsigned clamp_src(int unsigned v);
    if (v < 1) return 1;
    if (v > MAX_SRC_EDGE) return MAX_SRC_EDGE;
    return v;
  endfunction

  function automatic int unsigned clamp_dst(int unsigned v, int unsigned s);
    int unsigned lim;
    lim = (s < MAX_OUT_EDGE) ? s : MAX_OUT_EDGE;
    if (v < 1) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  function automatic int unsigned edge_at(int unsigned k, int unsigned s, int unsigned d);
    longint unsigned p;
    p = longint'(k) * s;
    return int'(p / d);
  endfunction

  function automatic void restart_frame();
    int unsigned sw, sh;
    sw = clamp_src(reg_sw);
    sh = clamp_src(reg_sh);
    foreach (red_acc[i]) begin
      red_acc[i] = 0; green_acc[i] = 0; blue_acc[i] = 0;
    end
    px_col = 0; px_row = 0; cell_x = 0; cell_y = 0; band_start = 0;
    col_end = edge_at(1, sw, clamp_dst(reg_dw, sw));
    row_end = edge_at(1, sh, clamp_dst(reg_dh, sh));
  endfunction

  // Accumulate one source pixel; returns 1 with the mean when it closes a cell
  function automatic bit area_average(input logic [PIX_W-1:0] r, g, b,
                                      output cell_mean_t m);
    int unsigned sw, sh, dw, dh, c, x0, cnt, half;
    bit hit;
    sw = clamp_src(reg_sw); sh = clamp_src(reg_sh);
    dw = clamp_dst(reg_dw, sw); dh = clamp_dst(reg_dh, sh);
    c = cell_x % MAX_OUT_EDGE;
    hit = 1'b0;
    if (px_row == band_start) begin
      red_acc[c] = r; green_acc[c] = g; blue_acc[c] = b;
    end else begin
      red_acc[c] += r; green_acc[c] += g; blue_acc[c] += b;
    end
    if (px_col + 1 == col_end && px_row + 1 == row_end) begin
      x0 = edge_at(cell_x, sw, dw);
      cnt = (col_end - x0) * (row_end - band_start);
      half = cnt / 2;
      if (cnt == 0) cnt = 1;
      m.red = PIX_W'((red_acc[c] + half) / cnt);
      m.green = PIX_W'((green_acc[c] + half) / cnt);
      m.blue = PIX_W'((blue_acc[c] + half) / cnt);
      m.col = DST_W'(cell_x);
      m.row = DST_W'(cell_y);
      m.frame_end = (cell_x + 1 == dw && cell_y + 1 == dh);
      hit = 1'b1;
    end
    px_col++;
    if (px_col >= sw) begin
      px_col = 0; cell_x = 0;
      col_end = edge_at(1, sw, dw);
      px_row++;
      if (px_row >= sh) restart_frame();
      else if (px_row >= row_end) begin
        cell_y++;
        band_start = px_row;
        row_end = edge_at(cell_y + 1, sh, dh);
      end
    end else if (px_col >= col_end) begin
      cell_x++;
      col_end = edge_at(cell_x + 1, sw, dw);
    end
    return hit;
  endfunction

  task automatic report(string what);
    $display("MISMATCH %s at %0t", what, $realtime);
    fail_count++;
  endtask

  // Offer one pixel and wait for the transfer; in_valid stays up for the next one
  task automatic send_pixel(logic [PIX_W-1:0] r, g, b, bit typed, cell_mean_t tm);
    cell_mean_t m;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_red <= r; in_green <= g; in_blue <= b;
    do @(posedge clk); while (in_stall);
    if (area_average(r, g, b, m)) begin
      if (typed) m = tm;
      mean_q.insert(mean_q.size(), m);
    end else if (typed) report("directed pixel predicted no output");
    @(negedge clk);
  endtask

  // Drain, let in-flight pixels settle, then write one register
  task automatic write_reg(logic [CIDX_W-1:0] idx, int unsigned v);
    while (mean_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en <= 1'b1; cfg_index <= idx; cfg_wdata <= SRC_W'(v);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_SRC_WIDTH:  reg_sw = v & 13'h1FFF;
      CFG_SRC_HEIGHT: reg_sh = v & 13'h1FFF;
      CFG_DST_WIDTH:  reg_dw = v & 10'h3FF;
      default:        reg_dh = v & 10'h3FF;
    endcase
    restart_frame();
  endtask

  task automatic set_size(int unsigned sw, sh, dw, dh);
    write_reg(CFG_SRC_WIDTH, sw);
    write_reg(CFG_SRC_HEIGHT, sh);
    write_reg(CFG_DST_WIDTH, dw);
    write_reg(CFG_DST_HEIGHT, dh);
  endtask

  task automatic random_pixels(int n);
    cell_mean_t none;
    for (int i = 0; i < n; i++)
      send_pixel(PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom), 1'b0, none);
    in_valid <= 1'b0;
  endtask

  // Result checker
  always @(posedge clk) begin
    cell_mean_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (mean_q.size() == 0) report("output with nothing expected");
      else begin
        e = mean_q.pop_front();
        if (out_red !== e.red) report($sformatf("red %0d exp %0d", out_red, e.red));
        if (out_green !== e.green) report($sformatf("green %0d exp %0d", out_green, e.green));
        if (out_blue !== e.blue) report($sformatf("blue %0d exp %0d", out_blue, e.blue));
        if (out_col !== e.col) report($sformatf("col %0d exp %0d", out_col, e.col));
        if (out_row !== e.row) report($sformatf("row %0d exp %0d", out_row, e.row));
        if (out_frame_end !== e.frame_end) report("frame_end");
      end
    end
  end

  // Receiver stalls: random bursts, one long hold on request
  always begin
    @(negedge clk);
    if (hold_req) begin
      out_stall <= 1'b1;
      repeat (HOLD_CYCLES) @(negedge clk);
      hold_req = 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    out_stall <= 1'b0;
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en || !rst_n)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    pixel_row_t dir_rows[$];
    pixel_row_t pr;
    logic [PIX_W-1:0] pat[20];
    pat = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80, 8'hFE, 8'h7F,
            8'h0F, 8'hF0, 8'h33, 8'hCC, 8'h00, 8'hFF, 8'h12, 8'hED,
            8'h69, 8'h96, 8'h3C, 8'hC3};
    reg_sw = 640; reg_sh = 640; reg_dw = 640; reg_dh = 640;
    restart_frame();
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Reset size: every first-row pixel is its own one-pixel cell
    for (int i = 0; i < 20; i++) begin
      pr.red = pat[i]; pr.green = ~pat[i]; pr.blue = pat[(i + 7) % 20];
      pr.typed = 1'b1;
      pr.mean = '{pr.red, pr.green, pr.blue, DST_W'(i), '0, 1'b0};
      dir_rows.insert(dir_rows.size(), pr);
    end
    foreach (dir_rows[i])
      send_pixel(dir_rows[i].red, dir_rows[i].green, dir_rows[i].blue,
                 dir_rows[i].typed, dir_rows[i].mean);
    in_valid <= 1'b0;

    // Zero sizes clamp to 1x1: every pixel is a whole frame
    set_size(0, 0, 0, 0);
    random_pixels(30);

    // Oversized source and output clamp to 4096 wide / 640 cells; long output hold
    set_size(8191, 32, 1023, 32);
    hold_req = 1'b1;
    random_pixels(200);

    // Full small frame at a random output size, no idling at the end
    set_size(32, 32, $urandom_range(1, 32), $urandom_range(1, 32));
    random_pixels(700);
    quiet = 1'b1;
    random_pixels(324);

    while (mean_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
`default_nettype wire

[filelist.f]
hdl/bdr_pkg.sv
hdl/bdr_ram.sv
hdl/bdr_div.sv
hdl/bdr_dp.sv
hdl/bdr_ctrl.sv
hdl/box_downscale_rgb.sv
tb/tb_top.sv
